### design/salc_pkg.sv
package salc_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int SETS         = 1 << MAX_SET_BITS;
  localparam int LINES        = SETS * MAX_WAYS;
  localparam int WAY_W        = $clog2(MAX_WAYS);
  localparam int LINE_W       = $clog2(LINES);
  localparam int SET_W        = MAX_SET_BITS;

  // access operations
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_IFETCH = 2'd3;

  // register indexes
  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_WAYS     = 2'd1;
  localparam logic [1:0] REG_OFF_BITS = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_in;   // capture item, compute tag/set, bump access count unless fetch
    logic rd_way;    // issue read of current way
    logic eval_way;  // examine read data of current way
    logic commit;    // write line and update totals
    logic out_take;  // result beat taken downstream
  } salc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_ifetch;
    logic last_way;
    logic clearing;  // valid-bit clearing pass still running
    logic out_busy;
  } salc_sts_t;

endpackage

### design/set_assoc_lru_cache_model.sv
// Set-associative cache with LRU replacement.
// An access's result is registered at commit, after the read port has walked ways_in_use
//   ways (clamped to 1..8); commit waits while a stalled result is still held. An
//   instruction fetch gives no result. Accesses are taken one at a time: the input is stalled
//   while the single read port of the line store is walked one way per cycle, and through the commit and done states.
// Reset (rst_n, synchronous): access count, totals and registers cleared at once (ways set to 1);
//   the valid bits are cleared by a pass over all 512 lines after reset, with the input stalled.
module set_assoc_lru_cache_model (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [63:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_was_hit,
  output logic        out_was_eviction,
  output logic        out_second_hit,
  output logic [31:0] out_total_hits,
  output logic [31:0] out_total_misses,
  output logic [31:0] out_total_evictions,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import salc_pkg::*;

  logic [2:0] cfg_set_bits_r;
  logic [3:0] cfg_ways_r;
  logic [5:0] cfg_off_bits_r;
  salc_cmd_t  cmd;
  salc_sts_t  sts;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_set_bits_r <= '0;
      cfg_ways_r     <= 4'd1;
      cfg_off_bits_r <= '0;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      if (paddr[3:2] == REG_SET_BITS) cfg_set_bits_r <= pwdata[2:0];
      if (paddr[3:2] == REG_WAYS)     cfg_ways_r     <= pwdata[3:0];
      if (paddr[3:2] == REG_OFF_BITS) cfg_off_bits_r <= pwdata[5:0];
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_SET_BITS: prdata = 32'(cfg_set_bits_r);
      REG_WAYS:     prdata = 32'(cfg_ways_r);
      REG_OFF_BITS: prdata = 32'(cfg_off_bits_r);
      default:      prdata = '0;
    endcase
  end

  salc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  salc_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_op               (in_op),
    .in_address          (in_address),
    .set_bits            (cfg_set_bits_r),
    .ways_cfg            (cfg_ways_r),
    .off_bits            (cfg_off_bits_r),
    .out_valid           (out_valid),
    .out_was_hit         (out_was_hit),
    .out_was_eviction    (out_was_eviction),
    .out_second_hit      (out_second_hit),
    .out_total_hits      (out_total_hits),
    .out_total_misses    (out_total_misses),
    .out_total_evictions (out_total_evictions)
  );

endmodule

### design/salc_datapath.sv
module salc_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  salc_pkg::salc_cmd_t   cmd,
  output salc_pkg::salc_sts_t   sts,
  input  logic [1:0]            in_op,
  input  logic [63:0]           in_address,
  input  logic [2:0]            set_bits,
  input  logic [3:0]            ways_cfg,
  input  logic [5:0]            off_bits,
  output logic                  out_valid,
  output logic                  out_was_hit,
  output logic                  out_was_eviction,
  output logic                  out_second_hit,
  output logic [31:0]           out_total_hits,
  output logic [31:0]           out_total_misses,
  output logic [31:0]           out_total_evictions
);
  import salc_pkg::*;

  // line store: valid, tag and stamp in memories
  logic             valid_mem [LINES];
  logic [63:0]      tag_mem [LINES];
  logic [31:0]      stamp_mem [LINES];
  logic [63:0]      rd_tag_r;
  logic [31:0]      rd_stamp_r;
  logic             rd_valid_r;
  logic             clr_busy_r;
  logic [LINE_W-1:0] clr_idx_r;

  logic [1:0]       op_r;
  logic [63:0]      tag_r;
  logic [SET_W-1:0] set_r;
  logic [3:0]       nways_r;
  logic [WAY_W-1:0] way_r;
  logic [31:0]      acc_r;
  logic             hit_r, found_inv_r;
  logic [WAY_W-1:0] hit_way_r, vic_way_r;
  logic [31:0]      vic_stamp_r;
  logic [31:0]      hits_r, misses_r, evicts_r;
  logic             ov_r, oh_r, oe_r, os_r;

  logic [2:0]       sb;
  logic [6:0]       sh_tag;
  logic [63:0]      set_full;
  logic [LINE_W-1:0] rd_addr, wr_addr;

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  assign sb       = (set_bits > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits;
  assign sh_tag   = 7'(sb) + 7'(off_bits);
  assign set_full = in_address >> off_bits;
  assign rd_addr  = {set_r, way_r};

  // read port of the line store
  always_ff @(posedge clk) begin
    if (cmd.rd_way) begin
      rd_tag_r   <= tag_mem[rd_addr];
      rd_stamp_r <= stamp_mem[rd_addr];
      rd_valid_r <= valid_mem[rd_addr];
    end
  end

  wire match_now = rd_valid_r && (rd_tag_r == tag_r);

  // write port
  always_comb begin
    priority if (hit_r)     wr_addr = {set_r, hit_way_r};
    else                    wr_addr = {set_r, vic_way_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      stamp_mem[wr_addr] <= acc_r;
      if (!hit_r) tag_mem[wr_addr] <= tag_r;
    end
  end

  // clearing pass over the valid bits, one line per cycle after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == LINE_W'(LINES - 1)) clr_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) valid_mem[clr_idx_r] <= 1'b0;
    else if (cmd.commit && !hit_r) valid_mem[wr_addr] <= 1'b1;
  end

  // access setup and per-way search
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r        <= in_op;
      tag_r       <= (sh_tag >= 7'd64) ? 64'd0 : (in_address >> sh_tag);
      set_r       <= SET_W'(set_full) & SET_W'((7'd1 << sb) - 7'd1);
      nways_r     <= (ways_cfg == 4'd0) ? 4'd1 :
                     (ways_cfg > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : ways_cfg;
      way_r       <= '0;
      hit_r       <= 1'b0;
      found_inv_r <= 1'b0;
      vic_way_r   <= '0;
    end else begin
      // way_r runs one ahead of the way under evaluation
      if (cmd.rd_way) way_r <= way_r + 1'b1;
      if (cmd.eval_way && !hit_r) begin
        if (match_now) begin
          hit_r     <= 1'b1;
          hit_way_r <= WAY_W'(way_r - 1'b1);
        end
        // victim search: first invalid, else smallest stamp (first on tie)
        if (!found_inv_r) begin
          if (!rd_valid_r) begin
            found_inv_r <= 1'b1;
            vic_way_r   <= WAY_W'(way_r - 1'b1);
          end else if (way_r == WAY_W'(1) || rd_stamp_r < vic_stamp_r) begin
            vic_way_r   <= WAY_W'(way_r - 1'b1);
            vic_stamp_r <= rd_stamp_r;
          end
        end
      end
    end
  end

  // control state: counters, result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      if (cmd.load_in && in_op != OP_IFETCH) acc_r <= acc_r + 32'd1;
      if (cmd.out_take) ov_r <= 1'b0;
      if (cmd.commit) begin
        logic [31:0] h;
        h = hits_r;
        if (hit_r) h = sat_inc(h);
        else begin
          misses_r <= sat_inc(misses_r);
          if (!found_inv_r) evicts_r <= sat_inc(evicts_r);
        end
        if (op_r == OP_MODIFY) h = sat_inc(h);
        hits_r <= h;
        ov_r   <= 1'b1;
        oh_r   <= hit_r;
        oe_r   <= !hit_r && !found_inv_r;
        os_r   <= (op_r == OP_MODIFY);
      end
    end
  end

  assign sts.is_ifetch = (in_op == OP_IFETCH);
  assign sts.last_way  = (way_r == WAY_W'(nways_r - 4'd1));
  assign sts.clearing  = clr_busy_r;
  assign sts.out_busy  = ov_r;

  assign out_valid           = ov_r;
  assign out_was_hit         = oh_r;
  assign out_was_eviction    = oe_r;
  assign out_second_hit      = os_r;
  assign out_total_hits      = hits_r;
  assign out_total_misses    = misses_r;
  assign out_total_evictions = evicts_r;

endmodule

### design/salc_ctrl.sv
module salc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 out_stall,
  input  salc_pkg::salc_sts_t  sts,
  output salc_pkg::salc_cmd_t  cmd
);
  import salc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_EVAL = 5'b00100,
    S_LAST = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;
  logic   take;

  assign take     = sts.out_busy && !out_stall;
  assign in_stall = !(state_r == S_IDLE) || sts.clearing;

  // sequencer: issue one way read per cycle, evaluate each way in the cycle after its read
  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    cmd          = '0;
    cmd.out_take = take;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !sts.clearing) begin
          cmd.load_in = 1'b1;
          if (!sts.is_ifetch) state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_way = 1'b1;
        last_nxt   = sts.last_way;
        state_nxt  = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval_way = 1'b1;
        if (last_r) state_nxt = S_LAST;
        else begin
          cmd.rd_way = 1'b1;
          last_nxt   = sts.last_way;
        end
      end
      S_LAST: begin
        // result register must be free before commit
        if (!sts.out_busy || take) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

endmodule
